// ===== design/utf8d_pkg.sv =====
package utf8d_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QPtrW      = $clog2(QueueDepth);
    localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

    localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [7:0]  LEAD2_LO   = 8'hC2;
    localparam logic [7:0]  LEAD2_HI   = 8'hDF;
    localparam logic [7:0]  LEAD3_LO   = 8'hE0;
    localparam logic [7:0]  LEAD3_HI   = 8'hEF;
    localparam logic [7:0]  LEAD4_LO   = 8'hF0;
    localparam logic [7:0]  LEAD4_HI   = 8'hF4;
    localparam logic [7:0]  LEAD_E0    = 8'hE0;
    localparam logic [7:0]  LEAD_ED    = 8'hED;
    localparam logic [7:0]  LEAD_F0    = 8'hF0;
    localparam logic [7:0]  LEAD_F4    = 8'hF4;
    localparam logic [7:0]  CONT_LO    = 8'h80;
    localparam logic [7:0]  CONT_HI    = 8'hBF;
    localparam logic [7:0]  E0_SEC_LO  = 8'hA0;
    localparam logic [7:0]  ED_SEC_HI  = 8'h9F;
    localparam logic [7:0]  F0_SEC_LO  = 8'h90;
    localparam logic [7:0]  F4_SEC_HI  = 8'h8F;
    localparam logic [7:0]  CONT_MASK  = 8'hC0;

    typedef enum logic [1:0] {
        CLS_WAIT,
        CLS_BAD,
        CLS_GOOD
    } utf8d_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } utf8d_state_t;

    // one queued byte, tagged by the front with its lead length (0 = never a lead)
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eoi;
        logic [2:0] lead_len;
    } utf8d_item_t;

    typedef struct packed {
        logic        valid;
        utf8d_item_t item;
    } utf8d_qhead_t;

    typedef struct packed {
        utf8d_kind_t kind;
        logic [2:0]  len;
        logic [20:0] cp;
    } utf8d_cls_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic        string_done;
        logic        run_last;
    } utf8d_result_t;

    function automatic logic [2:0] utf8d_lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b < CONT_LO)                        len = 3'd1;
        else if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
        return len;
    endfunction

    function automatic logic utf8d_second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (lead == LEAD_E0)      lo = E0_SEC_LO;
        else if (lead == LEAD_ED) hi = ED_SEC_HI;
        else if (lead == LEAD_F0) lo = F0_SEC_LO;
        else if (lead == LEAD_F4) hi = F4_SEC_HI;
        return (b >= lo) && (b <= hi);
    endfunction

    // examine the avail oldest bytes of b as one sequence start
    function automatic utf8d_cls_t utf8d_classify(input logic [3:0][7:0] b,
                                                  input logic [2:0]      len,
                                                  input logic [2:0]      avail);
        utf8d_cls_t r;
        logic       bad;
        bad = (len == 3'd0);
        if (avail >= 3'd2 && len >= 3'd2 && !utf8d_second_ok(b[0], b[1])) bad = 1'b1;
        if (avail >= 3'd3 && len >= 3'd3 && (b[2] & CONT_MASK) != CONT_LO) bad = 1'b1;
        if (avail >= 3'd4 && len >= 3'd4 && (b[3] & CONT_MASK) != CONT_LO) bad = 1'b1;
        r.len = len;
        case (len)
            3'd1:    r.cp = {14'd0, b[0][6:0]};
            3'd2:    r.cp = {10'd0, b[0][4:0], b[1][5:0]};
            3'd3:    r.cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            3'd4:    r.cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: r.cp = REPL_CHAR;
        endcase
        if (bad)              r.kind = CLS_BAD;
        else if (avail < len) r.kind = CLS_WAIT;
        else                  r.kind = CLS_GOOD;
        return r;
    endfunction

endpackage

// ===== design/utf8d_in_if.sv =====
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== design/utf8d_out_if.sv =====
interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        replaced;
    logic        string_done;
    logic        run_last;

    modport source (output valid, output code_point, output replaced,
                    output string_done, output run_last, input ready);
    modport sink   (input valid, input code_point, input replaced,
                    input string_done, input run_last, output ready);
endinterface

// ===== design/utf8_stream_decoder.sv =====
// Channel | Dir | Beat payload
// bytes   | in  | in_byte[7:0], end_of_input
// chars   | out | code_point[20:0], replaced, string_done, run_last
//
// Each byte is loaded into the decoder to start a step; the step then emits its
// results, each held in a staging register until the next result or the close
// of the step moves it to the output register. The close of a step and the load
// of the next byte share a cycle. The two-entry byte queue accepts bytes while it
// has room, also while the decoder works or the output register waits. Reset clears
// queue, pending count and output valid; pending bytes are don't-care until written.
module utf8_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    bytes,
    utf8d_out_if.source chars
);
    import utf8d_pkg::*;

    utf8d_qhead_t head;
    logic         pop;

    utf8d_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .head  (head),
        .pop   (pop)
    );

    utf8d_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .chars (chars)
    );

`ifndef SYNTHESIS
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.string_done |-> chars.run_last)
        else $error("string_done without run_last");

    a_repl_value: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && chars.replaced |-> chars.code_point == REPL_CHAR)
        else $error("replacement beat carries wrong code point");

    a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
        chars.valid && !chars.replaced |->
            chars.code_point <= 21'h10FFFF &&
            (chars.code_point < 21'h00D800 || chars.code_point > 21'h00DFFF))
        else $error("decoded value is not a scalar value");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("decoder pulled from an empty queue");
`endif

endmodule

// ===== design/utf8d_front.sv =====
module utf8d_front (
    input  logic                  clk,
    input  logic                  rst_n,
    utf8d_in_if.sink              bytes,
    output utf8d_pkg::utf8d_qhead_t head,
    input  logic                  pop
);
    import utf8d_pkg::*;

    utf8d_item_t            q_mem_reg [QueueDepth];
    logic [QPtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0]       cnt_reg, cnt_next;
    logic                   push;
    logic                   do_pop;

    assign bytes.ready = (cnt_reg != QCntW'(QueueDepth));
    assign push        = bytes.valid && bytes.ready;
    assign do_pop      = pop && (cnt_reg != '0);

    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= '{data_byte: bytes.in_byte,
                                       eoi:       bytes.end_of_input,
                                       lead_len:  utf8d_lead_len(bytes.in_byte)};
        end
    end

endmodule

// ===== design/utf8d_back.sv =====
module utf8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8d_pkg::utf8d_qhead_t head,
    output logic                    pop,
    utf8d_out_if.source             chars
);
    import utf8d_pkg::*;

    utf8d_state_t      state_reg, state_next;
    logic [3:0][7:0]   buf_reg, buf_next;
    logic [3:0][2:0]   lens_reg, lens_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              eoi_reg, eoi_next;
    logic              stage_valid_reg, stage_valid_next;
    utf8d_result_t     stage_reg, stage_next;
    logic              out_valid_reg, out_valid_next;
    utf8d_result_t     out_reg, out_next;

    utf8d_cls_t        cls;
    logic              adv;
    logic              stop;
    logic              produce;
    logic              load;
    logic [2:0]        consume;
    logic [3:0][7:0]   buf_sh;
    logic [3:0][2:0]   lens_sh;
    logic [2:0]        cnt_sh;

    assign cls     = utf8d_classify(buf_reg, lens_reg[0], cnt_reg);
    assign adv     = !out_valid_reg || chars.ready;
    // a step ends once nothing is left or an unfinished prefix may wait for more bytes
    assign stop    = (state_reg == ST_RUN) &&
                     ((cnt_reg == 3'd0) || (cls.kind == CLS_WAIT && !eoi_reg));
    assign produce = (state_reg == ST_RUN) && !stop && adv;
    assign load    = head.valid && ((state_reg == ST_IDLE) || (stop && adv));
    assign pop     = load;

    assign consume = (cls.kind == CLS_GOOD) ? cls.len : 3'd1;

    always_comb
    begin
        buf_sh  = buf_reg;
        lens_sh = lens_reg;
        cnt_sh  = cnt_reg;
        if (produce)
        begin
            buf_sh  = buf_reg >> {consume, 3'b000};
            lens_sh = lens_reg >> (4'(consume) * 4'd3);
            cnt_sh  = cnt_reg - consume;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (stop && adv && !load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        buf_next         = buf_sh;
        lens_next        = lens_sh;
        cnt_next         = cnt_sh;
        eoi_next         = eoi_reg;
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        out_valid_next   = out_valid_reg && !chars.ready;
        out_next         = out_reg;

        if (produce)
        begin
            stage_valid_next       = 1'b1;
            stage_next.code_point  = (cls.kind == CLS_GOOD) ? cls.cp : REPL_CHAR;
            stage_next.replaced    = (cls.kind != CLS_GOOD);
            stage_next.string_done = 1'b0;
            stage_next.run_last    = 1'b0;
            if (stage_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = stage_reg;
            end
        end

        if (stop && adv)
        begin
            stage_valid_next = 1'b0;
            if (stage_valid_reg)
            begin
                out_valid_next       = 1'b1;
                out_next             = stage_reg;
                out_next.run_last    = 1'b1;
                out_next.string_done = eoi_reg;
            end
        end

        if (load)
        begin
            buf_next[cnt_reg[1:0]]  = head.item.data_byte;
            lens_next[cnt_reg[1:0]] = head.item.lead_len;
            cnt_next                = cnt_reg + 3'd1;
            eoi_next                = head.item.eoi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            eoi_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            eoi_reg         <= eoi_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg   <= buf_next;
        lens_reg  <= lens_next;
        stage_reg <= stage_next;
        out_reg   <= out_next;
    end

    assign chars.valid       = out_valid_reg;
    assign chars.code_point  = out_reg.code_point;
    assign chars.replaced    = out_reg.replaced;
    assign chars.string_done = out_reg.string_done;
    assign chars.run_last    = out_reg.run_last;

endmodule
